// ===== rtl/kclc_pkg.sv =====
// Shared types and constants for the keypad code lock controller.
// Used by the core, the top level and the checker; depends on nothing.
package kclc_pkg;

    localparam int BLINK_TICKS_DEF = 62;
    localparam int CODE_KEYS_DEF   = 4;
    localparam int KEY_W           = 4;
    localparam int CODE_W          = 16;
    localparam int NUM_CODES       = 4;
    localparam logic [KEY_W-1:0] KEY_LIMIT = 4'd12;   // codes 12..15: no key

    localparam logic [15:0] ENTRY_TIMEOUT_RST   = 16'd10000;
    localparam logic [7:0]  DOOR_OPEN_TICKS_RST = 8'd5;
    localparam logic [15:0] LOCKOUT_TICKS_RST   = 16'd312;
    localparam logic [2:0]  MAX_ATTEMPTS_RST    = 3'd3;
    localparam logic [15:0] CODE_ZERO_RST       = 16'd4660;
    localparam logic [15:0] CODE_ONE_RST        = 16'd4112;
    localparam logic [15:0] CODE_TWO_RST        = 16'd10256;
    localparam logic [15:0] CODE_THREE_RST      = 16'd4867;

    // configuration register indexes
    localparam logic [2:0] REG_ENTRY_TIMEOUT   = 3'd0;
    localparam logic [2:0] REG_DOOR_OPEN_TICKS = 3'd1;
    localparam logic [2:0] REG_LOCKOUT_TICKS   = 3'd2;
    localparam logic [2:0] REG_MAX_ATTEMPTS    = 3'd3;
    localparam logic [2:0] REG_CODE_ZERO       = 3'd4;
    localparam logic [2:0] REG_CODE_ONE        = 3'd5;
    localparam logic [2:0] REG_CODE_TWO        = 3'd6;
    localparam logic [2:0] REG_CODE_THREE      = 3'd7;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_KEY_TAKEN   = 3'd1,
        EV_GRANTED     = 3'd2,
        EV_WRONG       = 3'd3,
        EV_LOCKOUT     = 3'd4,
        EV_TIMEOUT     = 3'd5,
        EV_DOOR_CLOSED = 3'd6,
        EV_LOCKOUT_END = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        MODE_ENTRY = 3'b001,
        MODE_OPEN  = 3'b010,
        MODE_LOCK  = 3'b100
    } mode_t;

    typedef struct packed {
        logic spk;
        logic red;
        logic green;
        logic door;
    } levels_t;

    typedef struct packed {
        logic [15:0]                   entry_timeout;
        logic [7:0]                    door_open_ticks;
        logic [15:0]                   lockout_ticks;
        logic [2:0]                    max_attempts;
        logic [NUM_CODES-1:0][CODE_W-1:0] codes;
    } cfg_t;

    typedef struct packed {
        event_t      ev;
        logic [1:0]  user_index;
        logic [2:0]  digits_entered;
        logic [2:0]  attempts_used;
        levels_t     lv;
    } result_t;

endpackage

// ===== rtl/kclc_core.sv =====
// Lock state and per-request step logic: key collection, code compare,
// door and lockout phases. Depends on kclc_pkg.
module kclc_core import kclc_pkg::*; #(
    parameter int BLINK_TICKS = BLINK_TICKS_DEF,
    parameter int CODE_KEYS   = CODE_KEYS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic             operation,
    input  logic [KEY_W-1:0] key_value,
    input  cfg_t             cfg,
    output result_t          result
);

    localparam int KCW = $clog2(CODE_KEYS + 1);
    localparam int BW  = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;
    localparam logic [BW-1:0]  BLINK_LAST = BW'(BLINK_TICKS - 1);
    localparam logic [16:0]    BLINK_W17  = 17'(BLINK_TICKS);
    localparam logic [KCW-1:0] KEYS_FULL  = KCW'(CODE_KEYS);
    localparam logic [CODE_W-1:0] CODE_MASK = (CODE_KEYS >= 4) ? 16'hFFFF :
        CODE_W'((32'd1 << (4 * (CODE_KEYS % 4))) - 32'd1);

    mode_t                  mode_reg,  mode_next;
    // [0] is the newest key; the current key completes the four-key window
    logic [2:0][KEY_W-1:0]  keys_reg,  keys_next;
    logic [KCW-1:0]         cnt_reg,   cnt_next;
    logic [15:0]            idle_reg,  idle_next;
    logic [2:0]             wrong_reg, wrong_next;
    logic [15:0]            phase_reg, phase_next;
    logic [BW-1:0]          blink_reg, blink_next;
    levels_t                lv_reg,    lv_next;

    logic [KCW-1:0]    cnt_inc;
    logic [15:0]       idle_inc;
    logic [15:0]       phase_sat;
    logic [2:0]        wrong_inc;
    logic [CODE_W-1:0] entry_val;
    logic              found;
    logic [1:0]        found_idx;
    logic              blink_toggle;
    event_t            ev;
    logic [1:0]        user;

    assign cnt_inc   = cnt_reg + 1'b1;
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign phase_sat = (phase_reg == 16'hFFFF) ? phase_reg : phase_reg + 16'd1;
    assign wrong_inc = wrong_reg + 3'd1;
    assign entry_val = {keys_reg, key_value} & CODE_MASK;

    // first matching code register wins
    always_comb begin
        found     = 1'b0;
        found_idx = 2'd0;
        for (int i = NUM_CODES - 1; i >= 0; i--) begin
            if ((cfg.codes[i] & CODE_MASK) == entry_val) begin
                found     = 1'b1;
                found_idx = 2'(i);
            end
        end
    end

    // blink at phase zero, and at each period boundary with a full period left
    assign blink_toggle = (phase_reg == 16'd0) ||
        ((blink_reg == '0) && ({1'b0, phase_reg} + BLINK_W17 <= {1'b0, cfg.lockout_ticks}));

    always_comb begin
        mode_next  = mode_reg;
        keys_next  = keys_reg;
        cnt_next   = cnt_reg;
        idle_next  = idle_reg;
        wrong_next = wrong_reg;
        phase_next = phase_reg;
        blink_next = blink_reg;
        lv_next    = lv_reg;
        ev         = EV_NONE;
        user       = 2'd0;

        unique case (mode_reg)
            MODE_OPEN: begin
                if (!operation) begin
                    phase_next = phase_sat;
                    if (phase_sat >= {8'd0, cfg.door_open_ticks}) begin
                        phase_next = 16'd0;
                        lv_next    = '0;
                        mode_next  = MODE_ENTRY;
                        ev         = EV_DOOR_CLOSED;
                    end
                end
            end
            MODE_LOCK: begin
                if (!operation) begin
                    if (phase_reg >= cfg.lockout_ticks) begin
                        phase_next = 16'd0;
                        blink_next = '0;
                        lv_next    = '0;
                        mode_next  = MODE_ENTRY;
                        ev         = EV_LOCKOUT_END;
                    end else begin
                        if (blink_toggle) begin
                            lv_next.red = ~lv_reg.red;
                            lv_next.spk = ~lv_reg.spk;
                        end
                        phase_next = phase_reg + 16'd1;
                        blink_next = (blink_reg == BLINK_LAST) ? '0 : blink_reg + 1'b1;
                    end
                end
            end
            default: begin
                // entry mode; an illegal code also recovers here
                mode_next   = MODE_ENTRY;
                lv_next.red = 1'b0;
                if (!operation) begin
                    if (idle_reg != 16'd0) begin
                        idle_next = idle_inc;
                        if (idle_inc >= cfg.entry_timeout) begin
                            keys_next   = '0;
                            cnt_next    = '0;
                            idle_next   = 16'd0;
                            lv_next.red = 1'b1;
                            ev          = EV_TIMEOUT;
                        end
                    end
                end else if (key_value < KEY_LIMIT) begin
                    keys_next = {keys_reg[1], keys_reg[0], key_value};
                    if (cnt_reg == '0) begin
                        idle_next = 16'd1;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc < KEYS_FULL) begin
                        ev = EV_KEY_TAKEN;
                    end else begin
                        keys_next  = '0;
                        cnt_next   = '0;
                        idle_next  = 16'd0;
                        phase_next = 16'd0;
                        blink_next = '0;
                        if (found) begin
                            user       = found_idx;
                            wrong_next = 3'd0;
                            mode_next  = MODE_OPEN;
                            lv_next    = '{spk: 1'b1, red: 1'b0, green: 1'b1, door: 1'b1};
                            ev         = EV_GRANTED;
                        end else if (wrong_inc >= cfg.max_attempts) begin
                            wrong_next = 3'd0;
                            mode_next  = MODE_LOCK;
                            lv_next    = '0;
                            ev         = EV_LOCKOUT;
                        end else begin
                            wrong_next  = wrong_inc;
                            lv_next.red = 1'b1;
                            ev          = EV_WRONG;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ENTRY;
            keys_reg  <= '0;
            cnt_reg   <= '0;
            idle_reg  <= 16'd0;
            wrong_reg <= 3'd0;
            phase_reg <= 16'd0;
            blink_reg <= '0;
            lv_reg    <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            keys_reg  <= keys_next;
            cnt_reg   <= cnt_next;
            idle_reg  <= idle_next;
            wrong_reg <= wrong_next;
            phase_reg <= phase_next;
            blink_reg <= blink_next;
            lv_reg    <= lv_next;
        end
    end

    assign result.ev             = ev;
    assign result.user_index     = user;
    assign result.digits_entered = 3'(cnt_next);
    assign result.attempts_used  = wrong_next;
    assign result.lv             = lv_next;

endmodule

// ===== rtl/keypad_code_lock_controller_unit.sv =====
// Keypad code lock controller: one result for every request (key or tick).
// Each result is registered into the output register (via the skid register
// if the output is stalled). Throughput: one request per cycle while s_tready
// is high; the two-entry output buffer keeps s_tready high until skid is full.
// Reset: synchronous on aresetn low; entry mode, all counters and levels zero,
// configuration registers back to their defaults.
module keypad_code_lock_controller_unit import kclc_pkg::*; #(
    parameter int BLINK_TICKS = BLINK_TICKS_DEF,
    parameter int CODE_KEYS   = CODE_KEYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [3:0] key_value, [7:4] zero
    input  logic [0:0]  s_tuser,    // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [1:0] user_index, [4:2] digits_entered,
                                    // [7:5] attempts_used, [8] door_open,
                                    // [9] green_led, [10] red_led, [11] speaker
    output logic [2:0]  m_tuser,    // [2:0] event_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept, out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign accept    = s_tvalid & s_tready;
    assign out_free  = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entry_timeout   <= ENTRY_TIMEOUT_RST;
            cfg_reg.door_open_ticks <= DOOR_OPEN_TICKS_RST;
            cfg_reg.lockout_ticks   <= LOCKOUT_TICKS_RST;
            cfg_reg.max_attempts    <= MAX_ATTEMPTS_RST;
            cfg_reg.codes[0]        <= CODE_ZERO_RST;
            cfg_reg.codes[1]        <= CODE_ONE_RST;
            cfg_reg.codes[2]        <= CODE_TWO_RST;
            cfg_reg.codes[3]        <= CODE_THREE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENTRY_TIMEOUT:   cfg_reg.entry_timeout   <= cfg_data;
                REG_DOOR_OPEN_TICKS: cfg_reg.door_open_ticks <= cfg_data[7:0];
                REG_LOCKOUT_TICKS:   cfg_reg.lockout_ticks   <= cfg_data;
                REG_MAX_ATTEMPTS:    cfg_reg.max_attempts    <= cfg_data[2:0];
                REG_CODE_ZERO:       cfg_reg.codes[0]        <= cfg_data;
                REG_CODE_ONE:        cfg_reg.codes[1]        <= cfg_data;
                REG_CODE_TWO:        cfg_reg.codes[2]        <= cfg_data;
                REG_CODE_THREE:      cfg_reg.codes[3]        <= cfg_data;
                default: ;
            endcase
        end
    end

    kclc_core #(
        .BLINK_TICKS (BLINK_TICKS),
        .CODE_KEYS   (CODE_KEYS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .operation (s_tuser[0]),
        .key_value (s_tdata[3:0]),
        .cfg       (cfg_reg),
        .result    (res)
    );

    // output register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= accept;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (accept) begin
                    skid_reg <= res;
                end
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.ev;
    assign m_tdata  = {4'd0, out_reg.lv.spk, out_reg.lv.red, out_reg.lv.green,
                       out_reg.lv.door, out_reg.attempts_used, out_reg.digits_entered,
                       out_reg.user_index};

endmodule

// ===== rtl/kclc_checker.sv =====
// Port-level checks for the keypad code lock controller, bound to the top.
// Depends on kclc_pkg and keypad_code_lock_controller_unit.
module kclc_checker import kclc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // door relay and green lamp always move together
    a_door_green: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == m_tdata[9]))
        else $error("door_open and green_led differ");

    // a grant opens the door with the speaker on; only a grant names a user
    a_grant_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == EV_GRANTED) |-> (m_tdata[8] && m_tdata[11] && !m_tdata[10]))
        else $error("granted without open door and speaker");

    a_user_only_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_GRANTED) |-> (m_tdata[1:0] == 2'd0))
        else $error("user_index set without grant");

    // phase ends and lockout start leave everything off and the entry empty
    a_phase_end_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_DOOR_CLOSED || m_tuser == EV_LOCKOUT_END ||
                      m_tuser == EV_LOCKOUT))
        |-> (m_tdata[11:8] == 4'd0 && m_tdata[4:2] == 3'd0))
        else $error("levels or entry not cleared at phase change");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind keypad_code_lock_controller_unit kclc_checker u_kclc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
